### hdl/cp437u8_pkg.sv
// ----------------------------------------------------------------------------
// cp437u8_pkg
// Shared types, limits and the code page 437 upper-half table for the
// CP437 / code point to UTF-8 encoder.
// ----------------------------------------------------------------------------
package cp437u8_pkg;

  localparam int unsigned ValueW    = 21;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaxBytes  = 4;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // sequence length boundaries
  localparam logic [ValueW-1:0] Limit1B = ValueW'(128);
  localparam logic [ValueW-1:0] Limit2B = ValueW'(2048);
  localparam logic [ValueW-1:0] Limit3B = ValueW'(65536);
  localparam logic [ValueW-1:0] Limit4B = ValueW'(1114112);

  // action codes
  typedef enum logic {
    ACT_TRANSCODE = 1'b0,
    ACT_DIRECT    = 1'b1
  } action_e;

  // one encoded item waiting in the queue
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;    // bytes[0] goes out first
    logic [IdxW-1:0]                last_idx; // index of the final byte
    logic                           bad;      // code point out of range
  } entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // upper half of code page 437, bytes 0x80..0xff
  localparam logic [15:0] Cp437Hi [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

### hdl/cp437u8_front.sv
// ----------------------------------------------------------------------------
// cp437u8_front
// Classifies an incoming item: maps CP437 bytes to code points, picks the
// sequence length and builds all UTF-8 bytes of the item.
// ----------------------------------------------------------------------------
module cp437u8_front (
  input  logic                               action_i,
  input  logic [cp437u8_pkg::ValueW-1:0]     value_i,
  output cp437u8_pkg::entry_t                entry_o
);

  logic [cp437u8_pkg::ValueW-1:0] cp;
  logic [7:0]                     ch;

  // code point selection
  always_comb begin
    ch = value_i[7:0];
    if (action_i == cp437u8_pkg::ACT_DIRECT) begin
      cp = value_i;
    end else if (ch[7]) begin
      cp = cp437u8_pkg::ValueW'(cp437u8_pkg::Cp437Hi[ch[6:0]]);
    end else begin
      cp = cp437u8_pkg::ValueW'(ch);
    end
  end

  // utf-8 byte formation
  always_comb begin
    entry_o = '0;
    if (cp >= cp437u8_pkg::Limit4B) begin
      entry_o.bad      = 1'b1;
      entry_o.last_idx = cp437u8_pkg::IdxW'(0);
    end else if (cp < cp437u8_pkg::Limit1B) begin
      entry_o.bytes[0] = {1'b0, cp[6:0]};
      entry_o.last_idx = cp437u8_pkg::IdxW'(0);
    end else if (cp < cp437u8_pkg::Limit2B) begin
      entry_o.bytes[0] = {3'b110, cp[10:6]};
      entry_o.bytes[1] = {2'b10, cp[5:0]};
      entry_o.last_idx = cp437u8_pkg::IdxW'(1);
    end else if (cp < cp437u8_pkg::Limit3B) begin
      entry_o.bytes[0] = {4'b1110, cp[15:12]};
      entry_o.bytes[1] = {2'b10, cp[11:6]};
      entry_o.bytes[2] = {2'b10, cp[5:0]};
      entry_o.last_idx = cp437u8_pkg::IdxW'(2);
    end else begin
      entry_o.bytes[0] = {5'b11110, cp[20:18]};
      entry_o.bytes[1] = {2'b10, cp[17:12]};
      entry_o.bytes[2] = {2'b10, cp[11:6]};
      entry_o.bytes[3] = {2'b10, cp[5:0]};
      entry_o.last_idx = cp437u8_pkg::IdxW'(3);
    end
  end

endmodule

### hdl/cp437u8_fifo.sv
// ----------------------------------------------------------------------------
// cp437u8_fifo
// Short queue of encoded items between the front and the back end.
// ----------------------------------------------------------------------------
module cp437u8_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cp437u8_pkg::entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output cp437u8_pkg::head_t  head_o
);

  cp437u8_pkg::entry_t            mem_q [cp437u8_pkg::FifoDepth];
  logic [cp437u8_pkg::PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [cp437u8_pkg::PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [cp437u8_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                           do_push, do_pop;

  // status and head
  assign full_o       = (cnt_q == cp437u8_pkg::CntW'(cp437u8_pkg::FifoDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == cp437u8_pkg::PtrW'(cp437u8_pkg::FifoDepth - 1)) ?
                 '0 : wr_ptr_q + cp437u8_pkg::PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == cp437u8_pkg::PtrW'(cp437u8_pkg::FifoDepth - 1)) ?
                 '0 : rd_ptr_q + cp437u8_pkg::PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + cp437u8_pkg::CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - cp437u8_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### hdl/cp437u8_back.sv
// ----------------------------------------------------------------------------
// cp437u8_back
// Walks the head bytes one per cycle into an output register unless pop stalls.
// ----------------------------------------------------------------------------
module cp437u8_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cp437u8_pkg::head_t                    head_i,
  output logic                                  head_pop_o,
  output logic                                  empty_o,
  input  logic                                  pop_i,
  output logic [cp437u8_pkg::ByteW-1:0]         out_byte_o,
  output logic                                  last_o,
  output logic                                  bad_code_point_o
);

  logic [cp437u8_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                          valid_q, valid_d;
  logic [cp437u8_pkg::ByteW-1:0] byte_q;
  logic                          last_q, bad_q;
  logic                          load, at_last;

  // load the next byte when the output register is free or being taken
  assign load       = head_i.valid && (!valid_q || pop_i);
  assign at_last    = (idx_q == head_i.entry.last_idx);
  assign head_pop_o = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : idx_q + cp437u8_pkg::IdxW'(1);
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.entry.bytes[idx_q];
      last_q <= at_last;
      bad_q  <= head_i.entry.bad;
    end
  end

  assign empty_o          = !valid_q;
  assign out_byte_o       = byte_q;
  assign last_o           = last_q;
  assign bad_code_point_o = bad_q;

endmodule

### hdl/cp437_and_code_point_to_utf8.sv
// ----------------------------------------------------------------------------
// cp437_and_code_point_to_utf8
// Encodes CP437 bytes or raw code points as UTF-8, one byte per result item.
// ----------------------------------------------------------------------------
// an accepted item is written into the queue, then its first byte into the output register
// throughput: one input item per cycle while the two-entry queue has room;
//   the back end sends one byte per cycle while popped; an n-byte item holds it until all n go
// reset: asynchronous active low, clears the queue and the output register
module cp437_and_code_point_to_utf8 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              action_i,
  input  logic [cp437u8_pkg::ValueW-1:0]    value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [cp437u8_pkg::ByteW-1:0]     out_byte_o,
  output logic                              last_o,
  output logic                              bad_code_point_o
);

  cp437u8_pkg::entry_t entry;
  cp437u8_pkg::head_t  head;
  logic                head_pop;

  // classify and encode
  cp437u8_front u_front (
    .action_i (action_i),
    .value_i  (value_i),
    .entry_o  (entry)
  );

  // decoupling queue
  cp437u8_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (head_pop),
    .head_o  (head)
  );

  // byte serializer
  cp437u8_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_pop_o       (head_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .bad_code_point_o (bad_code_point_o)
  );

`ifndef NO_ASSERTIONS
  // an error item is a single zero byte
  a_bad_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_code_point_o) |-> (last_o && out_byte_o == '0))
    else $error("error item is not a single zero byte");

  // the rest of a sequence follows without a gap
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside a multi-byte sequence");

  // bytes before the last are never plain ascii
  a_multi_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> out_byte_o[7])
    else $error("non-final byte has the top bit clear");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the CP437 / code point to UTF-8 encoder against a UTF-8 predictor.
// A short table of corner items runs first, then about 500 random items.
// Push and pop both stall at random. Every byte that is popped is compared
// with the oldest expected byte.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NumRandom = 500;
  localparam int unsigned MaxShown  = 10;

  localparam logic [20:0] OneByteEnd   = 21'h000080;
  localparam logic [20:0] TwoByteEnd   = 21'h000800;
  localparam logic [20:0] ThreeByteEnd = 21'h010000;
  localparam logic [20:0] CodeSpaceEnd = 21'h110000;

  // code points for CP437 bytes 0x80..0xff
  localparam logic [15:0] Cp437Upper [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // one output byte as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } utf8_byte_t;

  // corner item; when typed, the expected bytes are right-aligned, first byte highest
  typedef struct packed {
    cp437u8_pkg::action_e act;
    logic [20:0]          value;
    logic                 typed;
    logic [2:0]           n_bytes;
    logic [31:0]          bytes;
    logic                 bad;
  } corner_item_t;

  localparam int unsigned NumCorner = 23;
  localparam corner_item_t CornerItems [NumCorner] = '{
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h000000, 1'b1, 3'd1, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h00007F, 1'b1, 3'd1, 32'h0000007F, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h000080, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h0000FF, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h00009E, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h0000B0, 1'b0, 3'd0, 32'h00000000, 1'b0},
    // value above a byte: only the low 8 bits count
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h1FFFFF, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_TRANSCODE, 21'h000100, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h000000, 1'b1, 3'd1, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h00007F, 1'b1, 3'd1, 32'h0000007F, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h000080, 1'b1, 3'd2, 32'h0000C280, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h0007FF, 1'b1, 3'd2, 32'h0000DFBF, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h000800, 1'b1, 3'd3, 32'h00E0A080, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h00FFFF, 1'b1, 3'd3, 32'h00EFBFBF, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h010000, 1'b1, 3'd4, 32'hF0908080, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h10FFFF, 1'b1, 3'd4, 32'hF48FBFBF, 1'b0},
    // code point too large
    '{cp437u8_pkg::ACT_DIRECT,    21'h110000, 1'b1, 3'd1, 32'h00000000, 1'b1},
    '{cp437u8_pkg::ACT_DIRECT,    21'h1FFFFF, 1'b1, 3'd1, 32'h00000000, 1'b1},
    // surrogates pass as plain three-byte sequences; the last rows are one four-byte and two out-of-range values
    '{cp437u8_pkg::ACT_DIRECT,    21'h00D800, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h00DFFF, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h1E0000, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h0AAAAA, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{cp437u8_pkg::ACT_DIRECT,    21'h155555, 1'b0, 3'd0, 32'h00000000, 1'b0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  cp437u8_pkg::action_e action_i = cp437u8_pkg::ACT_TRANSCODE;
  logic [20:0]          value_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 last_o;
  logic                 bad_code_point_o;

  utf8_byte_t  expected_bytes [$];
  int unsigned fail_count = 0;
  int unsigned pop_hold = 0;
  int unsigned cycle_count = 0;
  bit          rx_calm = 1'b0;

  cp437_and_code_point_to_utf8 dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .value_i          (value_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .bad_code_point_o (bad_code_point_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stall length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // queue the UTF-8 bytes one item should produce
  function automatic void predict_utf8(input cp437u8_pkg::action_e act,
                                       input logic [20:0] value);
    logic [20:0] cp;
    logic [7:0]  ch;
    utf8_byte_t  seq [4];
    int          n;
    ch = value[7:0];
    if (act == cp437u8_pkg::ACT_TRANSCODE) begin
      cp = ch[7] ? {5'd0, Cp437Upper[ch[6:0]]} : {13'd0, ch};
    end else begin
      cp = value;
    end
    for (int k = 0; k < 4; k++) seq[k] = '0;
    if (cp >= CodeSpaceEnd) begin
      seq[0] = '{data: 8'h00, last: 1'b1, bad: 1'b1};
      n = 1;
    end else if (cp < OneByteEnd) begin
      seq[0].data = cp[7:0];
      n = 1;
    end else if (cp < TwoByteEnd) begin
      seq[0].data = {3'b110, cp[10:6]};
      seq[1].data = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < ThreeByteEnd) begin
      seq[0].data = {4'b1110, cp[15:12]};
      seq[1].data = {2'b10, cp[11:6]};
      seq[2].data = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0].data = {5'b11110, cp[20:18]};
      seq[1].data = {2'b10, cp[17:12]};
      seq[2].data = {2'b10, cp[11:6]};
      seq[3].data = {2'b10, cp[5:0]};
      n = 4;
    end
    seq[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_bytes.push_back(seq[k]);
  endfunction

  // direct-mode code point, weighted over the sequence lengths
  function automatic logic [20:0] pick_code_point();
    case ($urandom_range(0, 9))
      0:       return 21'($urandom_range(0, 21'h00007F));
      1, 2:    return 21'($urandom_range(21'h000080, 21'h0007FF));
      3:       return 21'($urandom_range(21'h000800, 21'h00FFFF));
      4:       return 21'($urandom_range(21'h00D800, 21'h00DFFF));
      5, 6:    return 21'($urandom_range(21'h010000, 21'h10FFFF));
      7:       return 21'($urandom_range(21'h110000, 21'h1FFFFF));
      8:       return 21'($urandom);
      default: begin
        case ($urandom_range(0, 7))
          0:       return 21'h00007F;
          1:       return 21'h000080;
          2:       return 21'h0007FF;
          3:       return 21'h000800;
          4:       return 21'h00FFFF;
          5:       return 21'h010000;
          6:       return 21'h10FFFF;
          default: return 21'h110000;
        endcase
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxShown) $display("%0t: %s", $time, msg);
  endtask

  // drive one item and hold it until full reads low at a clock edge and it is taken, then possibly idle a while
  task automatic send_item(input cp437u8_pkg::action_e act, input logic [20:0] value,
                           input bit calm);
    int unsigned gap;
    push     <= 1'b1;
    action_i <= act;
    value_i  <= value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold push low until every queued byte has come out
  task automatic drain_output();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // pop side: random stalls, with calm stretches
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) rx_calm <= ($urandom_range(0, 3) == 0);
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= rx_calm ? 0 : pick_gap();
    end
  end

  // compare each popped byte with the oldest expectation
  always @(posedge clk_i) begin
    utf8_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b bad %0b",
                               out_byte_o, last_o, bad_code_point_o));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.data || last_o !== want.last ||
            bad_code_point_o !== want.bad) begin
          note_failure($sformatf("byte exp %02h/%0b/%0b got %02h/%0b/%0b (data/last/bad)",
                                 want.data, want.last, want.bad,
                                 out_byte_o, last_o, bad_code_point_o));
        end
      end
    end
  end

  // stimulus
  initial begin
    corner_item_t         row;
    logic [20:0]          value;
    cp437u8_pkg::action_e act;
    bit                   tx_calm;
    int unsigned          n;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner items
    for (int i = 0; i < NumCorner; i++) begin
      row = CornerItems[i];
      if (row.typed) begin
        n = 32'(row.n_bytes);
        for (int k = 0; k < n; k++) begin
          expected_bytes.push_back('{data: row.bytes[8*(n-1-k) +: 8],
                                     last: (k == n - 1), bad: row.bad});
        end
      end else begin
        predict_utf8(row.act, row.value);
      end
      send_item(row.act, row.value, 1'b0);
    end
    drain_output();

    // random items
    tx_calm = 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (i == NumRandom / 2) drain_output();
      if ($urandom_range(0, 9) < 4) begin
        act   = cp437u8_pkg::ACT_TRANSCODE;
        value = ($urandom_range(0, 99) < 85) ? 21'($urandom_range(0, 255)) : 21'($urandom);
      end else begin
        act   = cp437u8_pkg::ACT_DIRECT;
        value = pick_code_point();
      end
      predict_utf8(act, value);
      send_item(act, value, tx_calm);
    end

    // wind down
    drain_output();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
